### rtl/ulcp_pkg.sv
package ulcp_pkg;

   // Longest kept line is LINE_CAPACITY-1 bytes, newline excluded.
   localparam int LINE_CAPACITY = 64;
   localparam int LEN_W         = $clog2(LINE_CAPACITY);
   localparam int VALUE_W       = 24;
   localparam int PREFIX_LEN    = 7;

   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LX    = 8'h78;
   localparam logic [7:0] CHAR_UX    = 8'h58;

   localparam logic CMD_NOOP   = 1'b0;
   localparam logic CMD_SET_BG = 1'b1;

   typedef enum logic [2:0] {
      PH_PREFIX,
      PH_SPACE,
      PH_SIGN,
      PH_ZERO,
      PH_ZEROX,
      PH_DIGITS,
      PH_DONE,
      PH_FAIL
   } parse_phase_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] digit;
   } hex_digit_type;

   // "set_bg " one character per position
   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h73; // s
         3'd1:    ch = 8'h65; // e
         3'd2:    ch = 8'h74; // t
         3'd3:    ch = 8'h5F; // _
         3'd4:    ch = 8'h62; // b
         3'd5:    ch = 8'h67; // g
         3'd6:    ch = 8'h20; // space
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic hex_digit_type hex_value(input logic [7:0] c);
      hex_digit_type r;
      r.ok    = 1'b0;
      r.digit = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r.ok    = 1'b1;
         r.digit = c[3:0];
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         r.ok    = 1'b1;
         r.digit = c[3:0] + 4'd9;
      end
      return r;
   endfunction

endpackage

### rtl/uart_line_command_parser.sv
// Line command parser for a serial byte stream.
// Input channel (req_): one received byte per beat. Output channel (rsp_):
// one command beat per newline of a kept line: set_bg with a 24-bit colour,
// or noop with colour 0. Lines longer than LINE_CAPACITY-1 bytes are dropped
// and their newline gives no beat; other bytes give no beat at all.
// Parsing runs on the fly: each accepted byte updates the parse phase, the
// hex accumulator and a few flags, so no line buffer is kept.
// The command shows on rsp_ in the cycle after its newline beat.
// Throughput: one byte per cycle while req_stall is low, set by the single registered parse step.
// The result sits in an output register; it is drained and refilled in the
// same cycle, so req_stall rises only while a command waits and rsp_stall
// is high. A stalled command holds its value.
// Reset (synchronous, active high) empties the output register and puts the
// parser at the start of a line.
module uart_line_command_parser
   import ulcp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_command,
   output logic [VALUE_W-1:0] rsp_colour_value
);

   // line and parse state
   logic [LEN_W-1:0]   line_length_ff, line_length_in;
   logic               drop_line_ff, drop_line_in;
   parse_phase_type    phase_ff, phase_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               too_big_ff, too_big_in;
   logic               minus_ff, minus_in;
   logic               ended_ff, ended_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_command_ff, rsp_command_in;
   logic [VALUE_W-1:0] rsp_colour_ff, rsp_colour_in;

   logic               accept;
   logic               is_nl;
   logic               line_full;
   logic               do_feed;
   hex_digit_type      hd;
   parse_phase_type    feed_phase;
   logic               feed_add;
   logic               feed_minus;
   logic               line_ok;

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign is_nl     = (req_rx_byte == CHAR_NL);
   assign line_full = (line_length_ff >= LEN_W'(LINE_CAPACITY - 1));
   assign do_feed   = !is_nl && !line_full && !ended_ff && (req_rx_byte != CHAR_NUL);
   assign hd        = hex_value(req_rx_byte);

   // next parse phase for one fed byte
   always_comb begin
      feed_phase = phase_ff;
      case (phase_ff)
         PH_PREFIX: begin
            if (line_length_ff < LEN_W'(PREFIX_LEN) &&
                req_rx_byte == prefix_char(line_length_ff[2:0])) begin
               feed_phase = (line_length_ff == LEN_W'(PREFIX_LEN - 1)) ? PH_SPACE : PH_PREFIX;
            end else begin
               feed_phase = PH_FAIL;
            end
         end
         PH_SPACE, PH_SIGN: begin
            if (phase_ff == PH_SPACE &&
                req_rx_byte inside {CHAR_SPACE, [8'h09:8'h0D]}) begin
               feed_phase = PH_SPACE;
            end else if (phase_ff == PH_SPACE &&
                         (req_rx_byte == CHAR_PLUS || req_rx_byte == CHAR_MINUS)) begin
               feed_phase = PH_SIGN;
            end else if (req_rx_byte == CHAR_ZERO) begin
               feed_phase = PH_ZERO;
            end else if (hd.ok) begin
               feed_phase = PH_DIGITS;
            end else begin
               feed_phase = PH_FAIL;
            end
         end
         PH_ZERO: begin
            if (req_rx_byte == CHAR_LX || req_rx_byte == CHAR_UX) feed_phase = PH_ZEROX;
            else if (hd.ok)                                       feed_phase = PH_DIGITS;
            else if (req_rx_byte == CHAR_SPACE)                   feed_phase = PH_DONE;
            else                                                  feed_phase = PH_FAIL;
         end
         PH_ZEROX: begin
            feed_phase = hd.ok ? PH_DIGITS : PH_FAIL;
         end
         PH_DIGITS: begin
            if (hd.ok)                          feed_phase = PH_DIGITS;
            else if (req_rx_byte == CHAR_SPACE) feed_phase = PH_DONE;
            else                                feed_phase = PH_FAIL;
         end
         default: feed_phase = phase_ff;
      endcase
   end

   // datapath actions for one fed byte
   always_comb begin
      feed_add   = 1'b0;
      feed_minus = 1'b0;
      case (phase_ff)
         PH_SPACE: begin
            feed_minus = (req_rx_byte == CHAR_MINUS);
            feed_add   = hd.ok && req_rx_byte != CHAR_ZERO &&
                         !(req_rx_byte inside {CHAR_SPACE, [8'h09:8'h0D]});
         end
         PH_SIGN:   feed_add = hd.ok && (req_rx_byte != CHAR_ZERO);
         PH_ZERO:   feed_add = hd.ok;
         PH_ZEROX:  feed_add = hd.ok;
         PH_DIGITS: feed_add = hd.ok;
         default: begin
            feed_add   = 1'b0;
            feed_minus = 1'b0;
         end
      endcase
   end

   // "-0" still passes; any other negative value or overflow is noop
   assign line_ok = (phase_ff == PH_ZERO || phase_ff == PH_DIGITS || phase_ff == PH_DONE) &&
                    !too_big_ff && !(minus_ff && acc_ff != '0);

   always_comb begin
      line_length_in = line_length_ff;
      drop_line_in   = drop_line_ff;
      phase_in       = phase_ff;
      acc_in         = acc_ff;
      too_big_in     = too_big_ff;
      minus_in       = minus_ff;
      ended_in       = ended_ff;
      if (accept) begin
         if (is_nl) begin
            line_length_in = '0;
            drop_line_in   = 1'b0;
            phase_in       = PH_PREFIX;
            acc_in         = '0;
            too_big_in     = 1'b0;
            minus_in       = 1'b0;
            ended_in       = 1'b0;
         end else if (line_full) begin
            drop_line_in = 1'b1;
         end else begin
            line_length_in = line_length_ff + 1'b1;
            if (!ended_ff && req_rx_byte == CHAR_NUL) ended_in = 1'b1;
            if (do_feed) begin
               phase_in = feed_phase;
               if (feed_minus) minus_in = 1'b1;
               // overflow once the top nibble is nonzero before the shift
               if (feed_add && !too_big_ff) begin
                  if (acc_ff[VALUE_W-1 -: 4] != 4'd0) too_big_in = 1'b1;
                  acc_in = {acc_ff[VALUE_W-5:0], hd.digit};
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_command_in = rsp_command_ff;
      rsp_colour_in  = rsp_colour_ff;
      if (accept && is_nl && !drop_line_ff) begin
         rsp_valid_in   = 1'b1;
         rsp_command_in = line_ok ? CMD_SET_BG : CMD_NOOP;
         rsp_colour_in  = line_ok ? acc_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= '0;
         drop_line_ff   <= 1'b0;
         phase_ff       <= PH_PREFIX;
         acc_ff         <= '0;
         too_big_ff     <= 1'b0;
         minus_ff       <= 1'b0;
         ended_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         line_length_ff <= line_length_in;
         drop_line_ff   <= drop_line_in;
         phase_ff       <= phase_in;
         acc_ff         <= acc_in;
         too_big_ff     <= too_big_in;
         minus_ff       <= minus_in;
         ended_ff       <= ended_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_command_ff <= rsp_command_in;
      rsp_colour_ff  <= rsp_colour_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command      = rsp_command_ff;
   assign rsp_colour_value = rsp_colour_ff;

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

// Checks the line command parser end to end: lines of bytes go in on req_,
// commands come out on rsp_. A local model of the parse walks every accepted
// byte and queues the command that each kept line must give; the monitor pops
// and compares per field. Both channels idle and stall at random, except for
// one calm window where they run flat out.
module tb_top
   import ulcp_pkg::*;
;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 1000;
   localparam int CALM_FROM    = 1000;   // no idling on either side in here
   localparam int CALM_TO      = 1600;
   localparam int MAX_PRINTS   = 30;

   localparam logic [8*PREFIX_LEN-1:0] BG_PREFIX = "set_bg ";
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_VT  = 8'h0B;
   localparam logic [7:0] CHAR_FF  = 8'h0C;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [31:0] COLOUR_MAX = 32'h00FF_FFFF;

   typedef struct packed {
      logic               cmd;
      logic [VALUE_W-1:0] colour;
   } bg_cmd_type;

   // ---------------------------------------------------------------------
   // clock, reset, DUT
   // ---------------------------------------------------------------------
   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_stall   = 1'b0;
   logic               req_stall;
   logic               rsp_valid;
   logic               rsp_command;
   logic [VALUE_W-1:0] rsp_colour_value;

   always #4 clock = ~clock;

   uart_line_command_parser DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command      (rsp_command),
      .rsp_colour_value (rsp_colour_value)
   );

   // ---------------------------------------------------------------------
   // bookkeeping
   // ---------------------------------------------------------------------
   logic [7:0] rx_backlog[$];   // bytes waiting for the driver
   logic [7:0] line_buf[$];     // line under construction
   bg_cmd_type cmd_due[$];      // commands owed by the DUT, oldest first

   int unsigned cycle_count  = 0;
   int unsigned fail_count   = 0;
   int unsigned bytes_queued = 0;
   int unsigned bytes_taken  = 0;
   int unsigned set_bg_seen  = 0;
   int unsigned noop_seen    = 0;
   int unsigned lines_dropped = 0;
   bg_cmd_type  got_cmd;

   wire calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d commands still due",
                  cycle_count, cmd_due.size());
         $display("uart_line_command_parser: mismatch");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      if (fail_count <= MAX_PRINTS)
         $display("ERROR @%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // parse predictor: one call per accepted byte
   // ---------------------------------------------------------------------
   int unsigned     ln_len;
   logic            ln_drop;
   parse_phase_type ph;
   logic [31:0]     hex_acc;    // wide enough for one more nibble past 24 bits
   logic            hex_ovf;    // sticky: value went past 24 bits
   logic            neg_sign;
   logic            nul_seen;

   function automatic void start_line();
      ln_len   = 0;
      ln_drop  = 1'b0;
      ph       = PH_PREFIX;
      hex_acc  = '0;
      hex_ovf  = 1'b0;
      neg_sign = 1'b0;
      nul_seen = 1'b0;
   endfunction

   function automatic int nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   // saturates just past the 24-bit range and stays there
   function automatic void push_nibble(input int d);
      if (!hex_ovf) begin
         hex_acc = hex_acc * 16 + d;
         if (hex_acc > COLOUR_MAX) begin
            hex_ovf = 1'b1;
            hex_acc = COLOUR_MAX + 1;
         end
      end
   endfunction

   function automatic void parse_char(input logic [7:0] c);
      int  d;
      logic lead;
      d    = nibble_of(c);
      lead = (ph == PH_SPACE);
      case (ph)
         PH_PREFIX: begin
            if (ln_len < PREFIX_LEN &&
                c == BG_PREFIX[8*(PREFIX_LEN-1-ln_len) +: 8])
               ph = (ln_len == PREFIX_LEN-1) ? PH_SPACE : PH_PREFIX;
            else
               ph = PH_FAIL;
         end
         // leading blanks and the sign only count before anything else;
         // otherwise the space phase behaves like the after-sign phase
         PH_SPACE, PH_SIGN: begin
            if (lead && (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))) begin
               ph = PH_SPACE;
            end else if (lead && c == CHAR_PLUS) begin
               ph = PH_SIGN;
            end else if (lead && c == CHAR_MINUS) begin
               neg_sign = 1'b1;
               ph       = PH_SIGN;
            end else if (c == CHAR_ZERO) begin
               ph = PH_ZERO;
            end else if (d >= 0) begin
               push_nibble(d);
               ph = PH_DIGITS;
            end else begin
               ph = PH_FAIL;
            end
         end
         PH_ZERO: begin
            if (c == CHAR_LX || c == CHAR_UX) ph = PH_ZEROX;
            else if (d >= 0) begin
               push_nibble(d);
               ph = PH_DIGITS;
            end else if (c == CHAR_SPACE) ph = PH_DONE;
            else ph = PH_FAIL;
         end
         PH_ZEROX: begin
            if (d >= 0) begin
               push_nibble(d);
               ph = PH_DIGITS;
            end else ph = PH_FAIL;
         end
         PH_DIGITS: begin
            if (d >= 0) push_nibble(d);
            else if (c == CHAR_SPACE) ph = PH_DONE;
            else ph = PH_FAIL;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void predict_byte(input logic [7:0] c);
      logic       ok;
      bg_cmd_type want;
      if (c == CHAR_NL) begin
         if (ln_drop) begin
            lines_dropped++;
         end else begin
            // "-0" is still a valid set_bg 0; any other negative is not
            ok = (ph == PH_ZERO || ph == PH_DIGITS || ph == PH_DONE) &&
                 !hex_ovf && !(neg_sign && hex_acc != 0);
            want.cmd    = ok ? CMD_SET_BG : CMD_NOOP;
            want.colour = ok ? hex_acc[VALUE_W-1:0] : '0;
            cmd_due.push_back(want);
         end
         start_line();
      end else if (ln_len >= LINE_CAPACITY-1) begin
         ln_drop = 1'b1;
      end else begin
         // bytes past a NUL still count toward the length
         if (!nul_seen) begin
            if (c == CHAR_NUL) nul_seen = 1'b1;
            else parse_char(c);
         end
         ln_len++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // driver: one byte per beat from rx_backlog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_byte(req_rx_byte);
            bytes_taken++;
         end
         // a stalled beat holds valid and payload
         if (!req_valid || !req_stall) begin
            if (rx_backlog.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
               req_valid   <= 1'b1;
               req_rx_byte <= rx_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: compare each command beat with the oldest one due
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cmd_due.size() == 0) begin
               report_mismatch("command beat with nothing due, command",
                               32'(rsp_command), 32'(CMD_NOOP));
            end else begin
               got_cmd = cmd_due.pop_front();
               if (rsp_command !== got_cmd.cmd)
                  report_mismatch("command", 32'(rsp_command), 32'(got_cmd.cmd));
               if (rsp_colour_value !== got_cmd.colour)
                  report_mismatch("colour_value", 32'(rsp_colour_value),
                                  32'(got_cmd.colour));
               if (got_cmd.cmd == CMD_SET_BG) set_bg_seen++;
               else noop_seen++;
            end
         end
         rsp_stall <= !calm && ($urandom_range(99) < 21);
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   task automatic end_line();
      foreach (line_buf[i]) rx_backlog.push_back(line_buf[i]);
      rx_backlog.push_back(CHAR_NL);
      bytes_queued += line_buf.size() + 1;
      line_buf.delete();
   endtask

   function automatic logic [7:0] any_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == CHAR_NL) b = CHAR_VT;
      return b;
   endfunction

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(5))
         0, 1:    return CHAR_SPACE;
         2:       return CHAR_TAB;
         3:       return CHAR_VT;
         4:       return CHAR_FF;
         default: return CHAR_CR;
      endcase
   endfunction

   // mostly well-formed set_bg lines with random content; some corrupted,
   // some near or over the length limit, some plain noise or a cut-off prefix
   task automatic make_random_line();
      int         kind;
      int         n;
      int         nib;
      int         target;
      logic [7:0] hx;
      kind = $urandom_range(99);
      if (kind < 77 || (kind >= 87 && kind < 95)) begin
         add_text("set_bg ");
         repeat ($urandom_range(3)) line_buf.push_back(blank_byte());
         case ($urandom_range(9))
            0, 1:    line_buf.push_back(CHAR_PLUS);
            2, 3:    line_buf.push_back(CHAR_MINUS);
            default: begin
            end
         endcase
         case ($urandom_range(9))
            0, 1, 2: add_text("0x");
            3:       add_text("0X");
            default: begin
            end
         endcase
         n = ($urandom_range(3) == 0) ? $urandom_range(1, 9) : $urandom_range(1, 6);
         repeat (n) begin
            nib = $urandom_range(15);
            if (nib < 10) hx = 8'("0" + nib);
            else hx = 8'(($urandom_range(1) ? "a" : "A") + nib - 10);
            line_buf.push_back(hx);
         end
         case ($urandom_range(3))
            0: begin
            end
            1: begin
               line_buf.push_back(CHAR_SPACE);
               repeat ($urandom_range(5)) line_buf.push_back(any_byte());
            end
            2: begin
               line_buf.push_back(CHAR_NUL);
               repeat ($urandom_range(3)) line_buf.push_back(any_byte());
            end
            default: line_buf.push_back(any_byte());
         endcase
         if (kind >= 62 && kind < 77) begin
            line_buf[$urandom_range(line_buf.size()-1)] = any_byte();
         end else if (kind >= 87) begin
            // straddle the kept/dropped boundary, now and then go far past it
            target = ($urandom_range(4) == 0) ? $urandom_range(64, 130)
                                              : $urandom_range(58, 68);
            while (line_buf.size() < target) line_buf.push_back(CHAR_SPACE);
         end
      end else if (kind < 87) begin
         repeat ($urandom_range(24)) line_buf.push_back(any_byte());
      end else begin
         n = $urandom_range(PREFIX_LEN);
         for (int i = 0; i < n; i++)
            line_buf.push_back(BG_PREFIX[8*(PREFIX_LEN-1-i) +: 8]);
      end
      end_line();
   endtask

   initial begin
      start_line();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed lines
      add_text("set_bg 0");          end_line();   // lone zero
      add_text("set_bg FFFFFF");     end_line();   // largest value
      add_text("set_bg ffffff");     end_line();
      add_text("set_bg 1000000");    end_line();   // one past the largest
      add_text("set_bg 0x1000000 "); end_line();
      add_text("set_bg 000000000ffffff"); end_line(); // leading zeros
      add_text("set_bg -0");         end_line();   // negative zero is fine
      add_text("set_bg -0x0");       end_line();
      add_text("set_bg -1");         end_line();   // negative value
      add_text("set_bg +aBc");       end_line();
      add_text("set_bg 0XfF 123");   end_line();   // space ends the number
      add_text("set_bg 0 junk");     end_line();
      add_text("set_bg 0x");         end_line();   // 0x without digits
      add_text("set_bg 0x 5");       end_line();
      add_text("set_bg +-1");        end_line();
      add_text("set_bg 12x");        end_line();   // bad terminator
      add_text("SET_BG 1");          end_line();
      add_text("set_bg");            end_line();
      add_text("set_bg ");           end_line();   // no digits
      end_line();                                  // empty line
      add_text("set_bg ");                         // all blank kinds
      line_buf.push_back(CHAR_TAB);
      line_buf.push_back(CHAR_VT);
      line_buf.push_back(CHAR_FF);
      line_buf.push_back(CHAR_CR);
      add_text(" 12");
      end_line();
      add_text("set_bg 12");                       // NUL ends the string
      line_buf.push_back(CHAR_NUL);
      add_text("zz");
      end_line();
      line_buf.push_back(CHAR_NUL);                // NUL up front
      add_text("set_bg 5");
      end_line();
      add_text("set_bg 7 ");                       // high bytes after the number
      line_buf.push_back(8'hFF);
      line_buf.push_back(8'h80);
      end_line();
      add_text("set_bg 1");                        // longest kept line
      repeat (LINE_CAPACITY - 1 - 8) line_buf.push_back(CHAR_SPACE);
      end_line();
      add_text("set_bg 2");                        // one byte too long
      repeat (LINE_CAPACITY - 8) line_buf.push_back(CHAR_SPACE);
      end_line();
      repeat (200) line_buf.push_back(any_byte()); // far too long
      end_line();

      // hold off the sender until the directed commands have all come back
      while (rx_backlog.size() != 0 || req_valid || cmd_due.size() != 0)
         @(posedge clock);

      while (bytes_queued < bytes_taken + RANDOM_BYTES) make_random_line();

      while (rx_backlog.size() != 0 || req_valid || cmd_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);   // catch any stray command beat

      $display("Fed %0d bytes; checked %0d set_bg and %0d noop commands, %0d long lines dropped",
               bytes_taken, set_bg_seen, noop_seen, lines_dropped);
      $display("%0d field errors", fail_count);
      if (fail_count == 0)
         $display("uart_line_command_parser: match");
      else
         $display("uart_line_command_parser: mismatch");
      $finish;
   end

endmodule
